// ===== rtl/quadrature_wavetable_oscillator_assert.svh =====
// Assertion macros for the quadrature wavetable oscillator.
`ifndef QUADRATURE_WAVETABLE_OSCILLATOR_ASSERT_SVH
`define QUADRATURE_WAVETABLE_OSCILLATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define QWO_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("qwo assertion failed");

// Next-cycle implication.
`define QWO_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("qwo assertion failed");

`else

`define QWO_ASSERT_NOW(label, clk, rstn, ante, cons)
`define QWO_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/qwo_pkg.sv =====
// Shared constants, types and arithmetic helpers of the quadrature wavetable oscillator.
package qwo_pkg;

    localparam int unsigned TABLE_SIZE = 1024;
    localparam int unsigned FRAC_BITS  = 16;
    localparam int unsigned TABLE_BITS = $clog2(TABLE_SIZE);
    localparam int unsigned BANK_BITS  = TABLE_BITS - 1;
    localparam int unsigned BANK_DEPTH = TABLE_SIZE / 2;
    localparam int unsigned PHASE_W    = TABLE_BITS + FRAC_BITS;
    localparam int unsigned INC_W      = 26;
    localparam int unsigned ADDR_W     = 10;
    localparam int unsigned SAMPLE_W   = 18;
    localparam int unsigned DIFF_W     = SAMPLE_W + 1;
    localparam int unsigned PROD_W     = DIFF_W + FRAC_BITS + 1;
    localparam int unsigned SUM_W      = DIFF_W + 2;
    localparam int unsigned OP_W       = 2;

    localparam int unsigned S_TDATA_W  = ((ADDR_W + SAMPLE_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W  = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int unsigned PADDR_W    = 4;
    localparam int unsigned PDATA_W    = 32;

    localparam longint unsigned Q1   = 64'd1 << FRAC_BITS;
    localparam longint unsigned Q0_5 = 64'd1 << (FRAC_BITS - 1);

    // quadrature phase leads by a quarter of the table
    localparam logic [PHASE_W-1:0] QUARTER_PHASE = PHASE_W'((TABLE_SIZE / 4) * Q1);

    localparam int SAT_MAX = (1 <<< (SAMPLE_W - 1)) - 1;
    localparam int SAT_MIN = -(1 <<< (SAMPLE_W - 1));

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_INC = 2'd0,
        REG_INV = 2'd1,
        REG_UNI = 2'd2
    } reg_idx_t;

    function automatic sample_t sat_sample(input logic signed [SUM_W-1:0] v);
        sample_t r;
        if (v > SUM_W'(SAT_MAX)) begin
            r = sample_t'(SAT_MAX);
        end else if (v < SUM_W'(SAT_MIN)) begin
            r = sample_t'(SAT_MIN);
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    // optional saturating negation, then optional y/2 + 1/2
    function automatic sample_t post_map(input sample_t y, input logic inv, input logic uni);
        logic signed [SUM_W-1:0] w;
        sample_t t;
        t = y;
        if (inv) begin
            w = -SUM_W'(t);
            t = sat_sample(w);
        end
        if (uni) begin
            w = SUM_W'(t);
            w = (w >>> 1) + $signed(SUM_W'(Q0_5));
            t = sat_sample(w);
        end
        return t;
    endfunction

endpackage

// ===== rtl/quadrature_wavetable_oscillator.sv =====
// Quadrature wavetable oscillator top level: table banks, phase accumulators, pipeline, skid.
//
// Wavetable oscillator with an in-phase and a quadrature output. Each input
// request carries an opcode in s_tuser: a write loads one signed table entry,
// a restart sets the main phase to zero and the quadrature phase to a quarter
// table, a tick returns one output request (sample, quad_sample) and advances
// both phases by phase_increment, wrapping at the table length. Opcode 3 is
// dropped. Throughput is one request per clock cycle of any kind while the
// skid register is empty; every stage below is registered. That rate rests
// on the table being split into an even and an odd bank, each with two read
// ports, so that the four neighbor reads of one tick (two per phase) come out
// of the banks together. The pipeline is: bank read, difference times
// fraction, interpolation sum with saturation, then the output mapping
// (inversion, unipolar) into an output register backed by a skid register,
// so input requests keep flowing while one result waits on m_tready. A table
// write lands in the bank at its accept edge, so a tick accepted in the next
// cycle already reads the new entry. Entries never written read as garbage.
// Registers (APB, byte address 4*i): 0 phase_increment, 1 invert_output,
// 2 unipolar_output; write them only while the block is idle.

`include "quadrature_wavetable_oscillator_assert.svh"

module quadrature_wavetable_oscillator (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input requests
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [qwo_pkg::S_TDATA_W-1:0]    s_tdata,   // table_address, table_value, zero pad
    input  logic [qwo_pkg::OP_W-1:0]         s_tuser,   // opcode
    // output requests
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [qwo_pkg::M_TDATA_W-1:0]    m_tdata,   // sample, quad_sample, zero pad
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [qwo_pkg::PADDR_W-1:0]      paddr,
    input  logic [qwo_pkg::PDATA_W-1:0]      pwdata,
    output logic [qwo_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [qwo_pkg::INC_W-1:0] inc_reg;
    logic                      inv_reg;
    logic                      uni_reg;
    logic                      apb_wr;
    qwo_pkg::reg_idx_t         reg_idx;

    assign pready  = 1'b1;
    assign apb_wr  = psel & penable & pwrite;
    assign reg_idx = qwo_pkg::reg_idx_t'(paddr[qwo_pkg::PADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc_reg <= '0;
            inv_reg <= 1'b0;
            uni_reg <= 1'b0;
        end else if (apb_wr) begin
            case (reg_idx)
                qwo_pkg::REG_INC: inc_reg <= pwdata[qwo_pkg::INC_W-1:0];
                qwo_pkg::REG_INV: inv_reg <= pwdata[0];
                qwo_pkg::REG_UNI: uni_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            qwo_pkg::REG_INC: prdata = qwo_pkg::PDATA_W'(inc_reg);
            qwo_pkg::REG_INV: prdata = qwo_pkg::PDATA_W'(inv_reg);
            qwo_pkg::REG_UNI: prdata = qwo_pkg::PDATA_W'(uni_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Input decode and pipeline enable
    // ---------------------------------------------------------------
    logic                                   skid_valid_reg;
    logic                                   en;
    logic                                   s_acc;
    qwo_pkg::op_t                           op;
    logic [qwo_pkg::ADDR_W-1:0]             wr_addr;
    qwo_pkg::sample_t                       wr_value;
    logic                                   do_tick;
    logic                                   do_write;
    logic                                   do_restart;

    // the whole pipeline moves unless the skid register holds a result
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign s_acc    = s_tvalid & s_tready;
    assign op       = qwo_pkg::op_t'(s_tuser);
    assign wr_addr  = s_tdata[qwo_pkg::ADDR_W-1:0];
    assign wr_value = s_tdata[qwo_pkg::ADDR_W +: qwo_pkg::SAMPLE_W];

    always_comb begin
        do_tick    = 1'b0;
        do_write   = 1'b0;
        do_restart = 1'b0;
        case (op)
            qwo_pkg::OP_TICK:    do_tick    = s_acc;
            qwo_pkg::OP_WRITE:   do_write   = s_acc;
            qwo_pkg::OP_RESTART: do_restart = s_acc;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Phase accumulators (power-of-two table: wrap is truncation)
    // ---------------------------------------------------------------
    logic [qwo_pkg::PHASE_W-1:0] main_phase_reg, main_phase_next;
    logic [qwo_pkg::PHASE_W-1:0] quad_phase_reg, quad_phase_next;

    always_comb begin
        main_phase_next = main_phase_reg;
        quad_phase_next = quad_phase_reg;
        if (do_restart) begin
            main_phase_next = '0;
            quad_phase_next = qwo_pkg::QUARTER_PHASE;
        end else if (do_tick) begin
            main_phase_next = main_phase_reg + qwo_pkg::PHASE_W'(inc_reg);
            quad_phase_next = quad_phase_reg + qwo_pkg::PHASE_W'(inc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_phase_reg <= '0;
            quad_phase_reg <= qwo_pkg::QUARTER_PHASE;
        end else begin
            main_phase_reg <= main_phase_next;
            quad_phase_reg <= quad_phase_next;
        end
    end

    // ---------------------------------------------------------------
    // Banked table addressing: entry i sits in bank i[0] at row i>>1.
    // The pair (i, i+1) always covers one even and one odd entry.
    // ---------------------------------------------------------------
    logic [qwo_pkg::TABLE_BITS-1:0] idx_m, idx_q;
    logic [qwo_pkg::BANK_BITS-1:0]  ev_addr_m, od_addr_m, ev_addr_q, od_addr_q;

    assign idx_m     = main_phase_reg[qwo_pkg::PHASE_W-1:qwo_pkg::FRAC_BITS];
    assign idx_q     = quad_phase_reg[qwo_pkg::PHASE_W-1:qwo_pkg::FRAC_BITS];
    assign od_addr_m = idx_m[qwo_pkg::TABLE_BITS-1:1];
    assign od_addr_q = idx_q[qwo_pkg::TABLE_BITS-1:1];
    assign ev_addr_m = idx_m[qwo_pkg::TABLE_BITS-1:1] + qwo_pkg::BANK_BITS'(idx_m[0]);
    assign ev_addr_q = idx_q[qwo_pkg::TABLE_BITS-1:1] + qwo_pkg::BANK_BITS'(idx_q[0]);

    qwo_pkg::sample_t even_mem [0:qwo_pkg::BANK_DEPTH-1];
    qwo_pkg::sample_t odd_mem  [0:qwo_pkg::BANK_DEPTH-1];
    qwo_pkg::sample_t ev_m_rd_reg, ev_q_rd_reg, od_m_rd_reg, od_q_rd_reg;

    always_ff @(posedge aclk) begin
        if (do_write && !wr_addr[0]) begin
            even_mem[wr_addr[qwo_pkg::TABLE_BITS-1:1]] <= wr_value;
        end
        if (en) begin
            ev_m_rd_reg <= even_mem[ev_addr_m];
            ev_q_rd_reg <= even_mem[ev_addr_q];
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write && wr_addr[0]) begin
            odd_mem[wr_addr[qwo_pkg::TABLE_BITS-1:1]] <= wr_value;
        end
        if (en) begin
            od_m_rd_reg <= odd_mem[od_addr_m];
            od_q_rd_reg <= odd_mem[od_addr_q];
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: bank data in, difference times main fraction
    // ---------------------------------------------------------------
    logic                            v1_reg, v2_reg, v3_reg;
    logic [qwo_pkg::FRAC_BITS-1:0]   frac1_reg;
    logic                            swm1_reg, swq1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            frac1_reg <= main_phase_reg[qwo_pkg::FRAC_BITS-1:0];
            swm1_reg  <= idx_m[0];
            swq1_reg  <= idx_q[0];
        end
    end

    qwo_pkg::sample_t                    am1, bm1, aq1, bq1;
    logic signed [qwo_pkg::DIFF_W-1:0]   dm1, dq1;
    logic signed [qwo_pkg::PROD_W-1:0]   pm2_next, pq2_next;
    logic signed [qwo_pkg::FRAC_BITS:0]  frac1_s;

    always_comb begin
        // odd index: this entry is odd, the neighbor is even
        am1      = swm1_reg ? od_m_rd_reg : ev_m_rd_reg;
        bm1      = swm1_reg ? ev_m_rd_reg : od_m_rd_reg;
        aq1      = swq1_reg ? od_q_rd_reg : ev_q_rd_reg;
        bq1      = swq1_reg ? ev_q_rd_reg : od_q_rd_reg;
        dm1      = qwo_pkg::DIFF_W'(bm1) - qwo_pkg::DIFF_W'(am1);
        dq1      = qwo_pkg::DIFF_W'(bq1) - qwo_pkg::DIFF_W'(aq1);
        frac1_s  = $signed({1'b0, frac1_reg});
        pm2_next = dm1 * frac1_s;
        pq2_next = dq1 * frac1_s;
    end

    // ---------------------------------------------------------------
    // Stage 2: base plus floored product, saturate
    // ---------------------------------------------------------------
    qwo_pkg::sample_t                    am2_reg, aq2_reg;
    logic signed [qwo_pkg::PROD_W-1:0]   pm2_reg, pq2_reg;
    logic signed [qwo_pkg::SUM_W-1:0]    sm2, sq2;
    qwo_pkg::sample_t                    ym3_next, yq3_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            am2_reg <= am1;
            aq2_reg <= aq1;
            pm2_reg <= pm2_next;
            pq2_reg <= pq2_next;
        end
    end

    always_comb begin
        sm2      = qwo_pkg::SUM_W'(am2_reg) + qwo_pkg::SUM_W'(pm2_reg >>> qwo_pkg::FRAC_BITS);
        sq2      = qwo_pkg::SUM_W'(aq2_reg) + qwo_pkg::SUM_W'(pq2_reg >>> qwo_pkg::FRAC_BITS);
        ym3_next = qwo_pkg::sat_sample(sm2);
        yq3_next = qwo_pkg::sat_sample(sq2);
    end

    // ---------------------------------------------------------------
    // Stage 3: output mapping
    // ---------------------------------------------------------------
    qwo_pkg::sample_t ym3_reg, yq3_reg;
    qwo_pkg::sample_t res_m, res_q;

    always_ff @(posedge aclk) begin
        if (en) begin
            ym3_reg <= ym3_next;
            yq3_reg <= yq3_next;
        end
    end

    assign res_m = qwo_pkg::post_map(ym3_reg, inv_reg, uni_reg);
    assign res_q = qwo_pkg::post_map(yq3_reg, inv_reg, uni_reg);

    // tick marker down the pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= do_tick;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // ---------------------------------------------------------------
    // Output register with skid register
    // ---------------------------------------------------------------
    logic                                   out_valid_reg, out_valid_next;
    logic                                   skid_valid_next;
    logic [2*qwo_pkg::SAMPLE_W-1:0]         out_data_reg, out_data_next;
    logic [2*qwo_pkg::SAMPLE_W-1:0]         skid_data_reg, skid_data_next;
    logic [2*qwo_pkg::SAMPLE_W-1:0]         res_data;

    assign res_data = {res_q, res_m};

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (en) begin
            if (v3_reg) begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_data;
                end else begin
                    skid_valid_next = 1'b1;
                    skid_data_next  = res_data;
                end
            end else if (m_tready) begin
                out_valid_next = 1'b0;
            end
        end else if (m_tready) begin
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = qwo_pkg::M_TDATA_W'(out_data_reg);

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `QWO_ASSERT_NOW(a_quad_lead, aclk, aresetn, 1'b1,
        (quad_phase_reg - main_phase_reg) == qwo_pkg::QUARTER_PHASE)
    `QWO_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `QWO_ASSERT_NEXT(a_phase_hold, aclk, aresetn, !do_tick && !do_restart,
        $stable(main_phase_reg))
    `QWO_ASSERT_NEXT(a_result_lands, aclk, aresetn, en && v3_reg, out_valid_reg)

endmodule

// ===== tb/sv/quadrature_wavetable_oscillator_tb.sv =====
// Self-checking testbench of the quadrature wavetable oscillator: predicted samples vs. stream output.
module quadrature_wavetable_oscillator_tb;

    localparam int CLK_HALF = 2;
    // opcode 3 has no meaning; the block must drop it
    localparam logic [qwo_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    // cycles granted after the last result before a register write
    localparam int SETTLE_CYCLES = 8;
    // cycles watched for stray results at the end
    localparam int DRAIN_CYCLES = 16;
    localparam longint TIME_LIMIT = 2000000;
    // quadrature accumulator starts a quarter table ahead
    localparam logic [qwo_pkg::PHASE_W-1:0] QUAD_START =
        qwo_pkg::PHASE_W'(qwo_pkg::TABLE_SIZE / 4) << qwo_pkg::FRAC_BITS;
    localparam logic [qwo_pkg::INC_W-1:0] INC_ALL_ONES = {qwo_pkg::INC_W{1'b1}};

    typedef struct packed {
        qwo_pkg::sample_t in_phase;
        qwo_pkg::sample_t quadrature;
    } sample_pair_t;

    // ---------------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ---------------------------------------------------------------------------------
    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [qwo_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [qwo_pkg::OP_W-1:0]      s_tuser  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [qwo_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [qwo_pkg::PADDR_W-1:0]   paddr    = '0;
    logic [qwo_pkg::PDATA_W-1:0]   pwdata   = '0;
    logic [qwo_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    quadrature_wavetable_oscillator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #CLK_HALF aclk = ~aclk;

    // ---------------------------------------------------------------------------------
    // Oscillator predictor: own copy of phases, table and register settings
    // ---------------------------------------------------------------------------------
    logic [qwo_pkg::PHASE_W-1:0] main_acc;
    logic [qwo_pkg::PHASE_W-1:0] quad_acc;
    qwo_pkg::sample_t            wave_copy [qwo_pkg::TABLE_SIZE];
    logic [qwo_pkg::INC_W-1:0]   step_cfg;
    logic                        invert_cfg;
    logic                        unipolar_cfg;

    sample_pair_t       expected_samples [$];
    int                 mismatch_count = 0;

    function automatic qwo_pkg::sample_t clamp_sample(input longint v);
        if (v > qwo_pkg::SAT_MAX) return qwo_pkg::sample_t'(qwo_pkg::SAT_MAX);
        if (v < qwo_pkg::SAT_MIN) return qwo_pkg::sample_t'(qwo_pkg::SAT_MIN);
        return qwo_pkg::sample_t'(v);
    endfunction

    // Linear interpolation between the entry under the phase and its neighbor,
    // weighted by the main phase fraction; the product floors (arithmetic shift).
    function automatic longint lerp_table(input logic [qwo_pkg::PHASE_W-1:0] phase,
                                          input logic [qwo_pkg::FRAC_BITS-1:0] frac);
        logic [qwo_pkg::TABLE_BITS-1:0] here_idx;
        logic [qwo_pkg::TABLE_BITS-1:0] nb_idx;
        longint here_val;
        longint nb_val;
        longint span;
        here_idx = phase[qwo_pkg::PHASE_W-1:qwo_pkg::FRAC_BITS];
        nb_idx   = here_idx + 1'b1;         // last entry wraps to entry 0
        here_val = wave_copy[here_idx];
        nb_val   = wave_copy[nb_idx];
        span     = (nb_val - here_val) * longint'(frac);
        return here_val + (span >>> qwo_pkg::FRAC_BITS);
    endfunction

    // Optional saturating negation, then optional y/2 (floor) + 1/2 with saturation.
    function automatic qwo_pkg::sample_t shape_output(input qwo_pkg::sample_t y);
        longint w;
        w = y;
        if (invert_cfg) w = clamp_sample(-w);
        if (unipolar_cfg) w = clamp_sample((w >>> 1) + longint'(qwo_pkg::Q0_5));
        return qwo_pkg::sample_t'(w);
    endfunction

    // Applies one request to the predictor; returns 1 when it yields a sample pair.
    function automatic bit predict_request(input logic [qwo_pkg::OP_W-1:0] op,
                                           input logic [qwo_pkg::ADDR_W-1:0] addr,
                                           input qwo_pkg::sample_t value,
                                           output sample_pair_t result);
        logic [qwo_pkg::FRAC_BITS-1:0] frac;
        bit produced;
        produced = 1'b0;
        result   = '0;
        case (op)
            qwo_pkg::OP_WRITE: begin
                wave_copy[addr] = value;
            end
            qwo_pkg::OP_RESTART: begin
                main_acc = '0;
                quad_acc = QUAD_START;
            end
            qwo_pkg::OP_TICK: begin
                frac = main_acc[qwo_pkg::FRAC_BITS-1:0];
                result.in_phase   = shape_output(clamp_sample(lerp_table(main_acc, frac)));
                result.quadrature = shape_output(clamp_sample(lerp_table(quad_acc, frac)));
                // table length is a power of two: wrap is the natural overflow
                main_acc = main_acc + step_cfg;
                quad_acc = quad_acc + step_cfg;
                produced = 1'b1;
            end
            default: ;
        endcase
        return produced;
    endfunction

    // ---------------------------------------------------------------------------------
    // Result checker: every accepted output request against the oldest prediction
    // ---------------------------------------------------------------------------------
    always @(posedge aclk) begin
        sample_pair_t want;
        qwo_pkg::sample_t got_i;
        qwo_pkg::sample_t got_q;
        if (aresetn && m_tvalid && m_tready) begin
            got_i = m_tdata[qwo_pkg::SAMPLE_W-1:0];
            got_q = m_tdata[2*qwo_pkg::SAMPLE_W-1:qwo_pkg::SAMPLE_W];
            if (expected_samples.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result sample=%0d quad_sample=%0d",
                         $time, got_i, got_q);
            end else begin
                want = expected_samples.pop_front();
                if (got_i !== want.in_phase) begin
                    mismatch_count++;
                    $display("%0t: sample expected %0d actual %0d",
                             $time, want.in_phase, got_i);
                end
                if (got_q !== want.quadrature) begin
                    mismatch_count++;
                    $display("%0t: quad_sample expected %0d actual %0d",
                             $time, want.quadrature, got_q);
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Receiver: stall pattern that cycles through modes, plus an on-demand hold-off
    // ---------------------------------------------------------------------------------
    int rx_cycle      = 0;
    int hold_off_left = 0;

    always @(posedge aclk) begin
        rx_cycle++;
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_tready <= 1'b0;
        end else begin
            case ((rx_cycle / 97) % 4)
                0:       m_tready <= 1'b1;                         // no stalls
                1:       m_tready <= ($urandom_range(0, 3) != 0);  // light stalls
                2:       m_tready <= ($urandom_range(0, 9) < 3);   // heavy stalls
                default: m_tready <= ((rx_cycle % 6) < 3);         // regular on/off
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // Sender: bursts of random length with random gaps, occasional long bursts
    // ---------------------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_request(input logic [qwo_pkg::OP_W-1:0] op,
                                input logic [qwo_pkg::ADDR_W-1:0] addr,
                                input qwo_pkg::sample_t value);
        sample_pair_t outcome;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= qwo_pkg::S_TDATA_W'({value, addr});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (predict_request(op, addr, value, outcome)) expected_samples.push_back(outcome);
        if (burst_left > 0) begin
            burst_left--;       // valid stays high for the next request
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic stop_sending();
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Block is idle once every prediction is matched and the pipeline has settled.
    task automatic wait_idle();
        stop_sending();
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly in-range values, some full 18-bit patterns, some extremes.
    function automatic qwo_pkg::sample_t random_table_value();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return qwo_pkg::sample_t'($urandom);
        if (pick == 1) return qwo_pkg::sample_t'(int'(qwo_pkg::Q1));
        if (pick == 2) return qwo_pkg::sample_t'(-int'(qwo_pkg::Q1));
        return qwo_pkg::sample_t'(int'($urandom_range(0, 2 * qwo_pkg::Q1))
                                  - int'(qwo_pkg::Q1));
    endfunction

    task automatic send_random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 68)
            send_request(qwo_pkg::OP_TICK, qwo_pkg::ADDR_W'($urandom),
                         qwo_pkg::sample_t'($urandom));
        else if (pick < 88)
            send_request(qwo_pkg::OP_WRITE, qwo_pkg::ADDR_W'($urandom),
                         random_table_value());
        else if (pick < 94)
            send_request(qwo_pkg::OP_RESTART, qwo_pkg::ADDR_W'($urandom),
                         qwo_pkg::sample_t'($urandom));
        else
            send_request(OP_UNUSED, qwo_pkg::ADDR_W'($urandom),
                         qwo_pkg::sample_t'($urandom));
    endtask

    task automatic run_traffic(input int count);
        repeat (count) send_random_request();
    endtask

    // ---------------------------------------------------------------------------------
    // Register port: write, then read back in the next transfer
    // ---------------------------------------------------------------------------------
    task automatic write_register(input qwo_pkg::reg_idx_t idx,
                                  input logic [qwo_pkg::PDATA_W-1:0] value);
        logic [qwo_pkg::PDATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= qwo_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            qwo_pkg::REG_INC: begin
                step_cfg = value[qwo_pkg::INC_W-1:0];
                want = qwo_pkg::PDATA_W'(step_cfg);
            end
            qwo_pkg::REG_INV: begin
                invert_cfg = value[0];
                want = qwo_pkg::PDATA_W'(invert_cfg);
            end
            default: begin
                unipolar_cfg = value[0];
                want = qwo_pkg::PDATA_W'(unipolar_cfg);
            end
        endcase
        // read setup straight after the write access
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== want) begin
            mismatch_count++;
            $display("%0t: register %0d read expected %0h actual %0h", $time, idx, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_registers(input logic [qwo_pkg::INC_W-1:0] inc, input logic inv,
                                 input logic uni);
        write_register(qwo_pkg::REG_INC, qwo_pkg::PDATA_W'(inc));
        write_register(qwo_pkg::REG_INV, qwo_pkg::PDATA_W'(inv));
        write_register(qwo_pkg::REG_UNI, qwo_pkg::PDATA_W'(uni));
    endtask

    // ---------------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------------

    // every register at both extremes, checked by read-back
    task automatic test_register_readback();
        set_registers(INC_ALL_ONES, 1'b1, 1'b1);
        set_registers('0, 1'b0, 1'b0);
    endtask

    // every entry written once, so no tick ever reads an unwritten entry
    task automatic test_table_load();
        for (int a = 0; a < qwo_pkg::TABLE_SIZE; a++) begin
            send_request(qwo_pkg::OP_WRITE, qwo_pkg::ADDR_W'(a), random_table_value());
        end
    endtask

    task automatic test_edge_cases();
        // odd difference across the table end makes the floor visible
        send_request(qwo_pkg::OP_WRITE, qwo_pkg::ADDR_W'(0), qwo_pkg::sample_t'(-65535));
        send_request(qwo_pkg::OP_WRITE, qwo_pkg::ADDR_W'(1),
                     qwo_pkg::sample_t'(int'(qwo_pkg::Q1)));
        send_request(qwo_pkg::OP_WRITE, qwo_pkg::ADDR_W'(qwo_pkg::TABLE_SIZE - 1),
                     qwo_pkg::sample_t'(int'(qwo_pkg::Q1)));
        send_request(qwo_pkg::OP_WRITE, qwo_pkg::ADDR_W'(qwo_pkg::TABLE_SIZE / 4),
                     qwo_pkg::sample_t'(qwo_pkg::SAT_MAX));
        send_request(qwo_pkg::OP_WRITE, qwo_pkg::ADDR_W'(qwo_pkg::TABLE_SIZE / 4 + 1),
                     qwo_pkg::sample_t'(qwo_pkg::SAT_MIN));
        wait_idle();
        // 1023.5 entries per tick: second tick sits between the last entry and entry 0
        write_register(qwo_pkg::REG_INC, qwo_pkg::PDATA_W'({10'd1023, 16'h8000}));
        send_request(qwo_pkg::OP_RESTART, '0, '0);
        send_request(qwo_pkg::OP_TICK, '0, '0);
        send_request(qwo_pkg::OP_TICK, '0, '0);
        // must not touch entry 0
        send_request(OP_UNUSED, qwo_pkg::ADDR_W'(0), qwo_pkg::sample_t'(qwo_pkg::SAT_MAX));
        send_request(qwo_pkg::OP_TICK, '0, '0);
        // negating the most negative entry saturates
        send_request(qwo_pkg::OP_WRITE, qwo_pkg::ADDR_W'(0),
                     qwo_pkg::sample_t'(qwo_pkg::SAT_MIN));
        wait_idle();
        write_register(qwo_pkg::REG_INV, qwo_pkg::PDATA_W'(1'b1));
        send_request(qwo_pkg::OP_RESTART, '0, '0);
        send_request(qwo_pkg::OP_TICK, '0, '0);
        send_request(qwo_pkg::OP_TICK, '0, '0);
        wait_idle();
        // unipolar on top of inversion, then alone
        write_register(qwo_pkg::REG_UNI, qwo_pkg::PDATA_W'(1'b1));
        send_request(qwo_pkg::OP_RESTART, '0, '0);
        send_request(qwo_pkg::OP_TICK, '0, '0);
        send_request(qwo_pkg::OP_TICK, '0, '0);
        wait_idle();
        write_register(qwo_pkg::REG_INV, qwo_pkg::PDATA_W'(1'b0));
        send_request(qwo_pkg::OP_RESTART, '0, '0);
        send_request(qwo_pkg::OP_TICK, '0, '0);
        wait_idle();
        // largest increment: each tick steps both phases back by one fractional LSB, modulo the table
        set_registers(INC_ALL_ONES, 1'b0, 1'b0);
        send_request(qwo_pkg::OP_RESTART, '0, '0);
        repeat (3) send_request(qwo_pkg::OP_TICK, '0, '0);
    endtask

    task automatic test_random_traffic();
        for (int s = 0; s < 6; s++) begin
            wait_idle();
            case (s)
                0: set_registers('0, 1'b0, 1'b0);
                1: set_registers(qwo_pkg::INC_W'(qwo_pkg::Q1), 1'b1, 1'b0);
                2: set_registers(INC_ALL_ONES, 1'b0, 1'b1);
                3: set_registers(qwo_pkg::INC_W'($urandom_range(1, 4 * qwo_pkg::Q1)),
                                 1'b1, 1'b1);
                default: set_registers(qwo_pkg::INC_W'($urandom), 1'($urandom), 1'($urandom));
            endcase
            run_traffic(9);
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_receiver_holdoff();
        wait_idle();
        set_registers(qwo_pkg::INC_W'($urandom), 1'($urandom), 1'($urandom));
        hold_off_left = 150;
        run_traffic(24);
    endtask

    // sender pauses mid-traffic until every prediction is matched
    task automatic test_sender_pause();
        wait_idle();
        set_registers(qwo_pkg::INC_W'($urandom_range(1, 8 * qwo_pkg::Q1)), 1'($urandom),
                      1'($urandom));
        run_traffic(10);
        stop_sending();
        while (expected_samples.size() != 0) @(posedge aclk);
        run_traffic(10);
    endtask

    initial begin
        main_acc     = '0;
        quad_acc     = QUAD_START;
        step_cfg     = '0;
        invert_cfg   = 1'b0;
        unipolar_cfg = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_readback();
        test_table_load();
        test_edge_cases();
        test_random_traffic();
        test_receiver_holdoff();
        test_sender_pause();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIME_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
